/* hdl/rcam_pkg.sv */
// ----------------------------------------------------------------------------
// rcam_pkg
// Shared types and constants for the red-cyan anaglyph merge.
// ----------------------------------------------------------------------------
package rcam_pkg;

  localparam int MAX_WIDTH_DEF    = 4096;
  localparam int PAD_MULTIPLE_DEF = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W      = 8;
  localparam int STORE_W    = 2 * PIX_W;
  // pad count per row stays below PAD_MULTIPLE, which the user must keep at most 16; not enforced
  localparam int PAD_CW     = 4;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET = 13'd640;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH      = 2'd0,
    REG_SHIFT_CORRECTION = 2'd1,
    REG_HAS_ALPHA        = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] width;      // clamped width
    logic [CFG_DATA_W-1:0] shift_mag;  // |shift|
    logic                  neg;        // right eye delayed
    logic                  has_alpha;
  } cfg_t;

  typedef struct packed {
    logic              emit;     // item gives results
    logic              use_old;  // one eye comes from the delay store
    logic              neg;
    logic              last;     // last column of the row
    logic              alpha_en;
    logic [PAD_CW-1:0] pads;     // pad pixels after this one
  } item_ctl_t;

endpackage

/* hdl/rcam_pix_in_if.sv */
// ----------------------------------------------------------------------------
// rcam_pix_in_if
// Input pixel pair channel: left red/alpha and right green/blue.
// ----------------------------------------------------------------------------
interface rcam_pix_in_if import rcam_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] left_red;
  logic [PIX_W-1:0] left_alpha;
  logic [PIX_W-1:0] right_green;
  logic [PIX_W-1:0] right_blue;

  modport source (output valid, left_red, left_alpha, right_green, right_blue,
                  input ready);
  modport sink   (input valid, left_red, left_alpha, right_green, right_blue,
                  output ready);
endinterface

/* hdl/rcam_pix_out_if.sv */
// ----------------------------------------------------------------------------
// rcam_pix_out_if
// Output pixel channel with padding and row end flags.
// ----------------------------------------------------------------------------
interface rcam_pix_out_if import rcam_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic [PIX_W-1:0] out_alpha;
  logic             is_padding;
  logic             row_end;

  modport source (output valid, out_red, out_green, out_blue, out_alpha,
                  is_padding, row_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha,
                  is_padding, row_end, output ready);
endinterface

/* hdl/rcam_cfg_if.sv */
// ----------------------------------------------------------------------------
// rcam_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface rcam_cfg_if import rcam_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/rcam_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rcam_cfg_regs
// Configuration registers, width clamp and shift magnitude.
// ----------------------------------------------------------------------------
module rcam_cfg_regs import rcam_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  rcam_cfg_if.sink       cfg,
  output cfg_t           cfg_out,
  output logic           restart
);

  localparam int MAXW_C = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam logic [CFG_DATA_W-1:0] MAXW = CFG_DATA_W'(MAXW_C);

  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] shift_correction;
  logic                  has_alpha;
  logic                  wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= WIDTH_RESET;
      shift_correction <= '0;
      has_alpha        <= 1'b0;
    end else if (wr) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH:      image_width      <= cfg.data;
        REG_SHIFT_CORRECTION: shift_correction <= cfg.data;
        REG_HAS_ALPHA:        has_alpha        <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = wr && ((cfg.index == REG_IMAGE_WIDTH) ||
                     (cfg.index == REG_SHIFT_CORRECTION));
  end

  always_comb begin
    if (image_width == '0)
      cfg_out.width = CFG_DATA_W'(1);
    else if (image_width > MAXW)
      cfg_out.width = MAXW;
    else
      cfg_out.width = image_width;
    cfg_out.neg       = shift_correction[CFG_DATA_W-1];
    cfg_out.shift_mag = cfg_out.neg ? (~shift_correction + CFG_DATA_W'(1))
                                    : shift_correction;
    cfg_out.has_alpha = has_alpha;
  end

endmodule

/* hdl/rcam_delay_mem.sv */
// ----------------------------------------------------------------------------
// rcam_delay_mem
// Delay line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcam_delay_mem import rcam_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      wr_addr,
  input  logic [STORE_W-1:0] wr_data,
  input  logic               re,
  input  logic [AW-1:0]      rd_addr,
  output logic [STORE_W-1:0] rd_data
);

  logic [STORE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/rcam_col_ctrl.sv */
// ----------------------------------------------------------------------------
// rcam_col_ctrl
// Column counter, pad phase and store addressing for each accepted item.
// ----------------------------------------------------------------------------
module rcam_col_ctrl import rcam_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int PAD_MULTIPLE = PAD_MULTIPLE_DEF,
  parameter int CW           = $clog2(MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg_in,
  input  logic               restart,
  input  logic               accept,
  input  logic [PIX_W-1:0]   left_red,
  input  logic [PIX_W-1:0]   left_alpha,
  input  logic [PIX_W-1:0]   right_green,
  input  logic [PIX_W-1:0]   right_blue,
  output logic [CW-1:0]      wr_addr,
  output logic [CW-1:0]      rd_addr,
  output logic [STORE_W-1:0] wr_data,
  output item_ctl_t          ctl
);

  localparam int XW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
  localparam int PW = (PAD_MULTIPLE > 1) ? $clog2(PAD_MULTIPLE) : 1;
  localparam logic [PW-1:0] PHASE_TOP = PW'(PAD_MULTIPLE - 1);

  logic [CW-1:0] column_count;
  logic [CW-1:0] column_count_next;
  logic [PW-1:0] phase;        // output pixels of this row, modulo PAD_MULTIPLE
  logic [PW-1:0] phase_next;
  logic [PW-1:0] phase_inc;
  logic [XW-1:0] cx, wx, dx;
  logic          d_zero, in_range, emit_shift;

  always_comb begin
    cx         = XW'(column_count);
    wx         = XW'(cfg_in.width);
    dx         = XW'(cfg_in.shift_mag);
    d_zero     = (cfg_in.shift_mag == '0);
    in_range   = (dx < wx);
    emit_shift = !d_zero && in_range && (cx >= dx);

    ctl.last     = ((cx + XW'(1)) >= wx);
    ctl.emit     = d_zero || emit_shift;
    ctl.use_old  = !d_zero;
    ctl.neg      = cfg_in.neg;
    ctl.alpha_en = cfg_in.has_alpha;

    phase_inc = (phase == PHASE_TOP) ? '0 : phase + PW'(1);
    if (d_zero || phase_inc == '0)
      ctl.pads = '0;
    else
      ctl.pads = PAD_CW'(PAD_MULTIPLE - int'(phase_inc));

    column_count_next = ctl.last ? '0 : column_count + CW'(1);
    if (emit_shift)
      phase_next = ctl.last ? '0 : phase_inc;
    else
      phase_next = phase;

    wr_addr = column_count;
    rd_addr = CW'(cx - dx);
    wr_data = cfg_in.neg ? {right_blue, right_green} : {left_alpha, left_red};
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count <= '0;
      phase        <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      phase        <= phase_next;
    end
  end

endmodule

/* hdl/rcam_out_seq.sv */
// ----------------------------------------------------------------------------
// rcam_out_seq
// Merge stage and pad sequencer feeding the output register.
// ----------------------------------------------------------------------------
module rcam_out_seq import rcam_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  item_ctl_t          ctl,
  input  logic [PIX_W-1:0]   left_red,
  input  logic [PIX_W-1:0]   left_alpha,
  input  logic [PIX_W-1:0]   right_green,
  input  logic [PIX_W-1:0]   right_blue,
  input  logic [STORE_W-1:0] old_data,
  output logic               in_ready,
  rcam_pix_out_if.source     pix_out
);

  // merge stage: one item, its main pixel then any pad pixels
  logic              s1_valid;
  logic              s1_main;
  logic [PAD_CW-1:0] s1_rem;     // results still to follow the current one
  item_ctl_t         s1_ctl;
  logic [PIX_W-1:0]  s1_lr, s1_la, s1_rg, s1_rb;

  logic             o_valid;
  logic [PIX_W-1:0] o_red, o_green, o_blue, o_alpha;
  logic             o_pad, o_end;

  logic             o_free, s1_move, s1_fin, load;
  logic [PIX_W-1:0] m_red, m_green, m_blue, m_alpha;

  always_comb begin
    o_free   = !o_valid || pix_out.ready;
    s1_move  = s1_valid && o_free;
    s1_fin   = s1_move && (s1_rem == '0);
    in_ready = !s1_valid || s1_fin;
    load     = accept && ctl.emit;
  end

  always_comb begin
    m_red   = s1_lr;
    m_alpha = s1_la;
    m_green = s1_rg;
    m_blue  = s1_rb;
    if (s1_ctl.use_old) begin
      if (s1_ctl.neg) begin
        m_green = old_data[PIX_W-1:0];
        m_blue  = old_data[STORE_W-1:PIX_W];
      end else begin
        m_red   = old_data[PIX_W-1:0];
        m_alpha = old_data[STORE_W-1:PIX_W];
      end
    end
    if (!s1_ctl.alpha_en) m_alpha = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_fin) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctl  <= ctl;
      s1_main <= 1'b1;
      s1_rem  <= ctl.last ? ctl.pads : '0;
      s1_lr   <= left_red;
      s1_la   <= left_alpha;
      s1_rg   <= right_green;
      s1_rb   <= right_blue;
    end else if (s1_move) begin
      s1_main <= 1'b0;
      s1_rem  <= s1_rem - PAD_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_move) begin
      o_valid <= 1'b1;
    end else if (pix_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_red   <= s1_main ? m_red   : '0;
      o_green <= s1_main ? m_green : '0;
      o_blue  <= s1_main ? m_blue  : '0;
      o_alpha <= s1_main ? m_alpha : '0;
      o_pad   <= !s1_main;
      o_end   <= s1_ctl.last && (s1_rem == '0);
    end
  end

  assign pix_out.valid      = o_valid;
  assign pix_out.out_red    = o_red;
  assign pix_out.out_green  = o_green;
  assign pix_out.out_blue   = o_blue;
  assign pix_out.out_alpha  = o_alpha;
  assign pix_out.is_padding = o_pad;
  assign pix_out.row_end    = o_end;

endmodule

/* hdl/red_cyan_anaglyph_merge.sv */
// ----------------------------------------------------------------------------
// red_cyan_anaglyph_merge
// Merges lockstep left/right eye pixel streams into red-cyan anaglyph rows,
// with a signed horizontal eye shift, row crop and zero padding.
//
//   channel   role    carries
//   pix_in    sink    left red/alpha, right green/blue of one column
//   pix_out   source  merged pixel, is_padding, row_end
//   cfg       sink    register index and write data, always ready
//
// One pixel pair per clock while pix_out is ready; the last pair of a cropped row
// holds the input until its pad pixels (up to PAD_MULTIPLE-1) have moved on.
// Results are registered in the merge stage, with the store read, then in the output register.
// The delay store is written and read in the accept cycle; read data is
// never of the entry written in that cycle, so no forwarding is needed.
// Synchronous reset clears control state only; the store needs no clearing.
// ----------------------------------------------------------------------------
module red_cyan_anaglyph_merge import rcam_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int PAD_MULTIPLE = PAD_MULTIPLE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  rcam_pix_in_if.sink    pix_in,
  rcam_pix_out_if.source pix_out,
  rcam_cfg_if.sink       cfg
);

  localparam int CW = $clog2(MAX_WIDTH);

  cfg_t               cfg_cur;
  logic               restart;
  logic               accept;
  logic               in_ready;
  item_ctl_t          ctl;
  logic [CW-1:0]      wr_addr, rd_addr;
  logic [STORE_W-1:0] wr_data, rd_data;

  assign pix_in.ready = in_ready;
  assign accept       = pix_in.valid && in_ready;

  rcam_cfg_regs #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_out (cfg_cur),
    .restart (restart)
  );

  rcam_col_ctrl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .PAD_MULTIPLE (PAD_MULTIPLE),
    .CW           (CW)
  ) u_col (
    .clk         (clk),
    .rst         (rst),
    .cfg_in      (cfg_cur),
    .restart     (restart),
    .accept      (accept),
    .left_red    (pix_in.left_red),
    .left_alpha  (pix_in.left_alpha),
    .right_green (pix_in.right_green),
    .right_blue  (pix_in.right_blue),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .wr_data     (wr_data),
    .ctl         (ctl)
  );

  rcam_delay_mem #(.DEPTH(MAX_WIDTH), .AW(CW)) u_mem (
    .clk     (clk),
    .we      (accept),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .re      (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rcam_out_seq u_out (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .ctl         (ctl),
    .left_red    (pix_in.left_red),
    .left_alpha  (pix_in.left_alpha),
    .right_green (pix_in.right_green),
    .right_blue  (pix_in.right_blue),
    .old_data    (rd_data),
    .in_ready    (in_ready),
    .pix_out     (pix_out)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for red_cyan_anaglyph_merge. Left/right pixel pairs are driven
// through directed rows (zero shift, left and right eye delay, crop and
// padding, shift at or beyond the width, width clamping, widest settings),
// then random rows under random settings. A behavioural model of the merge
// predicts every output item, which is checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import rcam_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int MAX_WAIT       = 14;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 130;
  localparam int MAX_REPORTS    = 10;
  localparam int PAD_MULT       = PAD_MULTIPLE_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic             pad;
    logic             row_end;
  } anaglyph_pix_t;

  logic clk = 1'b0;
  logic rst;

  rcam_pix_in_if  pin ();
  rcam_pix_out_if pout ();
  rcam_cfg_if     cfg ();

  red_cyan_anaglyph_merge dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pin),
    .pix_out (pout),
    .cfg     (cfg)
  );

  always #HALF_PERIOD clk = ~clk;

  // model state
  logic [CFG_DATA_W-1:0]        width_reg;
  logic signed [CFG_DATA_W-1:0] shift_reg;
  logic                         alpha_reg;
  int                           column;
  logic [STORE_W-1:0]           eye_store [MAX_WIDTH_DEF];
  anaglyph_pix_t                merged_queue [$];

  int mismatches = 0;
  int idle_cycles = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;

  function automatic void predict_merge(logic [PIX_W-1:0] lr, logic [PIX_W-1:0] la,
                                        logic [PIX_W-1:0] rg, logic [PIX_W-1:0] rb);
    int w;
    int d;
    int c;
    int wc;
    int pads;
    logic neg;
    logic row_last;
    logic [PIX_W-1:0] a;
    logic [STORE_W-1:0] old;
    anaglyph_pix_t px;
    if (width_reg == 0) w = 1;
    else if (width_reg > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    else w = int'(width_reg);
    neg = shift_reg[CFG_DATA_W-1];
    d = neg ? -int'(shift_reg) : int'(shift_reg);
    c = column;
    row_last = (c + 1 >= w);
    if (c >= w) c = w - 1;
    column = row_last ? 0 : c + 1;

    if (d == 0) begin
      px.red = lr;
      px.green = rg;
      px.blue = rb;
      px.alpha = alpha_reg ? la : '0;
      px.pad = 1'b0;
      px.row_end = row_last;
      merged_queue.push_back(px);
      return;
    end
    if (d >= w) return;

    if (c >= d) begin
      old = eye_store[c - d];
      wc = w - d;
      pads = (wc % PAD_MULT != 0) ? PAD_MULT - wc % PAD_MULT : 0;
      if (neg) begin
        px.red = lr;
        a = la;
        px.green = old[PIX_W-1:0];
        px.blue = old[STORE_W-1:PIX_W];
      end else begin
        px.red = old[PIX_W-1:0];
        a = old[STORE_W-1:PIX_W];
        px.green = rg;
        px.blue = rb;
      end
      px.alpha = alpha_reg ? a : '0;
      px.pad = 1'b0;
      px.row_end = row_last && (pads == 0);
      merged_queue.push_back(px);
      if (row_last) begin
        for (int p = 0; p < pads; p++) begin
          px = '0;
          px.pad = 1'b1;
          px.row_end = (p + 1 == pads);
          merged_queue.push_back(px);
        end
      end
    end
    // the earlier eye is held back by d columns
    eye_store[c] = neg ? {rb, rg} : {la, lr};
  endfunction

  function automatic void report_field(string field, logic [PIX_W-1:0] want,
                                       logic [PIX_W-1:0] got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS)
        $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // model update and result check on each accepted item
  always @(posedge clk) begin
    anaglyph_pix_t got;
    anaglyph_pix_t want;
    if (!rst) begin
      idle_cycles++;
      if (cfg.valid && cfg.ready) begin
        idle_cycles = 0;
        case (cfg.index)
          REG_IMAGE_WIDTH: begin
            width_reg = cfg.data;
            column = 0;
          end
          REG_SHIFT_CORRECTION: begin
            shift_reg = cfg.data;
            column = 0;
          end
          REG_HAS_ALPHA: alpha_reg = cfg.data[0];
          default: ;
        endcase
      end
      if (pin.valid && pin.ready) begin
        idle_cycles = 0;
        predict_merge(pin.left_red, pin.left_alpha, pin.right_green, pin.right_blue);
      end
      if (pout.valid && pout.ready) begin
        idle_cycles = 0;
        got.red = pout.out_red;
        got.green = pout.out_green;
        got.blue = pout.out_blue;
        got.alpha = pout.out_alpha;
        got.pad = pout.is_padding;
        got.row_end = pout.row_end;
        if (merged_queue.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected output item: %h", got);
          mismatches++;
        end else begin
          want = merged_queue.pop_front();
          report_field("out_red", want.red, got.red);
          report_field("out_green", want.green, got.green);
          report_field("out_blue", want.blue, got.blue);
          report_field("out_alpha", want.alpha, got.alpha);
          report_field("is_padding", PIX_W'(want.pad), PIX_W'(got.pad));
          report_field("row_end", PIX_W'(want.row_end), PIX_W'(got.row_end));
        end
      end
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
    $display("timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("red_cyan_anaglyph_merge regression: fail");
    $finish;
  end

  // output side: random stall before each item
  initial begin
    int stall;
    forever begin
      stall = out_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall > 0) begin
        pout.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pout.ready <= 1'b1;
      do @(posedge clk); while (!(pout.valid && !rst));
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] lr, logic [PIX_W-1:0] la,
                            logic [PIX_W-1:0] rg, logic [PIX_W-1:0] rb);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      pin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin.valid <= 1'b1;
    pin.left_red <= lr;
    pin.left_alpha <= la;
    pin.right_green <= rg;
    pin.right_blue <= rb;
    do @(posedge clk); while (!pin.ready);
  endtask

  task automatic send_noise_pixels(int count);
    repeat (count)
      send_pixel(PIX_W'($urandom()), PIX_W'($urandom()), PIX_W'($urandom()),
                 PIX_W'($urandom()));
  endtask

  // drop valid, let every expected item out, then allow for items in flight
  task automatic wait_idle();
    pin.valid <= 1'b0;
    do @(posedge clk); while (merged_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic configure(int w, int s, bit alpha);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_SHIFT_CORRECTION, CFG_DATA_W'(s));
    write_reg(REG_HAS_ALPHA, CFG_DATA_W'(alpha));
    cfg.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_pixel(8'hff, 8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff, 8'hff);
    send_noise_pixels(1);
  endtask

  task automatic test_zero_shift();
    configure(3, 0, 1'b1);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_noise_pixels(1);
  endtask

  task automatic test_left_eye_delay();
    // cropped to 5, padded with 3
    configure(6, 1, 1'b1);
    send_noise_pixels(6);
    // cropped to 1: one pixel and three pads from the last column
    configure(2, 1, 1'b1);
    send_noise_pixels(2);
  endtask

  task automatic test_right_eye_delay();
    // cropped to 4, no padding
    configure(7, -3, 1'b0);
    send_noise_pixels(7);
  endtask

  task automatic test_shift_limits();
    configure(3, 3, 1'b1);
    send_noise_pixels(3);
    configure(1, -4096, 1'b1);
    send_noise_pixels(1);
    // alpha switched mid-row; spare index must change nothing
    configure(5, 2, 1'b1);
    send_noise_pixels(2);
    wait_idle();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
    write_reg(REG_HAS_ALPHA, '0);
    cfg.valid <= 1'b0;
    send_noise_pixels(3);
  endtask

  task automatic test_width_clamp();
    configure(0, 0, 1'b1);
    send_noise_pixels(2);
    configure(0, 1, 1'b0);
    send_noise_pixels(1);
  endtask

  task automatic test_widest_rows();
    // widest width, clamped to the store depth, then the largest shifts
    configure(8191, 0, 1'b1);
    send_noise_pixels(6);
    configure(8191, 4095, 1'b1);
    send_noise_pixels(4);
    configure(4096, -4095, 1'b1);
    send_noise_pixels(4);
  endtask

  task automatic test_random_rows();
    int w;
    int s;
    int rows;
    int sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      // now and then a shift at or past the width, where nothing comes out
      if ($urandom_range(0, 7) == 0) s = w + $urandom_range(0, 2);
      else if ($urandom_range(0, 5) == 0) s = 0;
      else s = $urandom_range(0, w - 1);
      if ($urandom_range(0, 1) == 1) s = -s;
      in_gaps_on = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      configure(w, s, 1'($urandom_range(0, 1)));
      rows = $urandom_range(1, 3);
      send_noise_pixels(rows * w);
      // broken row, restarted by the next register write
      if ($urandom_range(0, 3) == 0) send_noise_pixels($urandom_range(1, w));
      if ((s < 0 ? -s : s) < w) sent += rows * w;
    end
  endtask

  initial begin
    pin.valid <= 1'b0;
    pin.left_red <= '0;
    pin.left_alpha <= '0;
    pin.right_green <= '0;
    pin.right_blue <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    rst <= 1'b1;
    width_reg = WIDTH_RESET;
    shift_reg = '0;
    alpha_reg = 1'b0;
    column = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_zero_shift();
    test_left_eye_delay();
    test_right_eye_delay();
    test_shift_limits();
    test_width_clamp();
    test_widest_rows();
    test_random_rows();
    wait_idle();

    if (mismatches == 0) begin
      $display("red_cyan_anaglyph_merge regression: pass");
    end else begin
      $display("red_cyan_anaglyph_merge regression: fail");
    end
    $finish;
  end

endmodule
